// ===== sv/mcg_pkg.sv =====
// Shared constants and tables for the metronome click generator.
package mcg_pkg;

    localparam int SAMPLE_RATE      = 48000;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);

    localparam int LEN_W   = 11;
    localparam int PHASE_W = 24;
    localparam int Y_W     = 20;
    localparam int DECAY_Q16 = 567291;

    localparam logic [LEN_W-1:0] ACCENT_LEN = LEN_W'(SAMPLE_RATE * 15 / 1000);
    localparam logic [LEN_W-1:0] NORMAL_LEN = LEN_W'(SAMPLE_RATE * 10 / 1000);

    localparam logic [PHASE_W-1:0] ACCENT_STEP =
        PHASE_W'(((64'd1200 << PHASE_W) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
    localparam logic [PHASE_W-1:0] NORMAL_STEP =
        PHASE_W'(((64'd800 << PHASE_W) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));

    // decay exponent per click sample, split into quotient and remainder
    localparam logic [Y_W-1:0]   ACCENT_Q = Y_W'(DECAY_Q16 / int'(ACCENT_LEN));
    localparam logic [LEN_W-1:0] ACCENT_R = LEN_W'(DECAY_Q16 % int'(ACCENT_LEN));
    localparam logic [Y_W-1:0]   NORMAL_Q = Y_W'(DECAY_Q16 / int'(NORMAL_LEN));
    localparam logic [LEN_W-1:0] NORMAL_R = LEN_W'(DECAY_Q16 % int'(NORMAL_LEN));

    localparam logic [15:0] ACCENT_GAIN = 16'd32768;
    localparam logic [15:0] NORMAL_GAIN = 16'd22938;
    localparam logic [15:0] VOL_MAX     = 16'd32768;

    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21167;
    localparam logic [15:0] SIN_C = 16'd2463;

    localparam logic signed [26:0] SAT_MAX = 27'sd8388607;
    localparam logic signed [26:0] SAT_MIN = -27'sd8388608;

    localparam logic [7:0] REG_ENABLE        = 8'd0;
    localparam logic [7:0] REG_ACCENT_ENABLE = 8'd1;
    localparam logic [7:0] REG_VOLUME        = 8'd2;
    localparam logic [7:0] REG_BEATS_PER_BAR = 8'd3;

    // Q15 table of 2^(-j/16), j = 0..16
    function automatic logic [15:0] pow2_neg(input logic [4:0] j);
        logic [15:0] v;
        case (j)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd31379;
            5'd2:    v = 16'd30048;
            5'd3:    v = 16'd28775;
            5'd4:    v = 16'd27554;
            5'd5:    v = 16'd26386;
            5'd6:    v = 16'd25268;
            5'd7:    v = 16'd24196;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd22188;
            5'd10:   v = 16'd21247;
            5'd11:   v = 16'd20347;
            5'd12:   v = 16'd19484;
            5'd13:   v = 16'd18658;
            5'd14:   v = 16'd17867;
            5'd15:   v = 16'd17109;
            5'd16:   v = 16'd16384;
            default: v = 16'd16384;
        endcase
        return v;
    endfunction

    function automatic logic [23:0] sat24(input logic signed [26:0] v);
        logic [23:0] r;
        if (v > SAT_MAX)
        begin
            r = 24'h7FFFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 24'h800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/metronome_click_generator.sv =====
// Metronome click generator: beat detection, click synthesis and mixing.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    playing, beat_position, left_in, right_in
//  out      source     out_valid/out_ready  left_out, right_out
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample at a time through a sequencer around a single 32x32 multiplier.
// A click sample takes eight multiplier passes; a sample that starts a click
// first runs the bit-serial whole-beat modulo beats_per_bar. Reset clears the
// datapath and loads the config defaults (disabled, accent on, full volume,
// 4 beats per bar); cfg_ready is always high. A finished sample sits in
// the output register, so the next transaction is taken while it waits.
module metronome_click_generator
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               playing,
    input  logic signed [31:0] beat_position,
    input  logic signed [23:0] left_in,
    input  logic signed [23:0] right_in,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] left_out,
    output logic signed [23:0] right_out,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_CHECK,
        S_MOD,
        S_CLICK,
        S_ZZ,
        S_P1,
        S_P2,
        S_P3,
        S_ENV,
        S_GV,
        S_SE,
        S_ABG,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic enable_reg, enable_next;
    logic accent_en_reg, accent_en_next;
    logic [15:0] volume_reg, volume_next;
    logic [4:0] bpb_reg, bpb_next;

    logic lpv_reg, lpv_next;
    logic [15:0] lwb_reg, lwb_next;
    logic [mcg_pkg::LEN_W-1:0] crem_reg, crem_next;
    logic accent_reg, accent_next;
    logic [mcg_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [mcg_pkg::Y_W-1:0] yq_reg, yq_next;
    logic [mcg_pkg::LEN_W-1:0] yr_reg, yr_next;

    logic playing_reg, playing_next;
    logic signed [31:0] pos_reg, pos_next;
    logic signed [23:0] left_reg, left_next;
    logic signed [23:0] right_reg, right_next;

    logic [4:0] mod_rem_reg, mod_rem_next;
    logic [3:0] mod_cnt_reg, mod_cnt_next;
    logic [15:0] whole_reg, whole_next;

    logic [63:0] prod_reg, prod_next;
    logic [15:0] z2_reg, z2_next;
    logic [15:0] sabs_reg, sabs_next;
    logic [15:0] env_reg, env_next;
    logic [30:0] gv_reg, gv_next;
    logic signed [25:0] click_reg, click_next;

    logic out_valid_reg, out_valid_next;
    logic [23:0] left_out_reg, left_out_next;
    logic [23:0] right_out_reg, right_out_next;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // sine folding
    logic [15:0] u;
    logic [14:0] r_fold;
    logic [15:0] z;

    // envelope pieces
    logic [3:0]  env_i;
    logic [11:0] env_fr;
    logic [15:0] tab_lo, tab_hi;
    logic [15:0] env_e;

    // misc
    logic [4:0]  bpb_eff;
    logic [5:0]  mod_t;
    logic [15:0] cw;
    logic [mcg_pkg::LEN_W-1:0] clk_len;
    logic [mcg_pkg::LEN_W:0]   yr_sum;
    logic        y_carry;
    logic [15:0] vol_eff;
    logic [24:0] mag;
    logic signed [26:0] left_sum, right_sum;

    assign mul_p = mul_a * mul_b;

    assign u = {phase_reg[mcg_pkg::PHASE_W-1 -: mcg_pkg::SINE_BITS],
                {(16 - mcg_pkg::SINE_BITS){1'b0}}};
    assign r_fold = u[14] ? (15'd16384 - {1'b0, u[13:0]}) : {1'b0, u[13:0]};
    assign z = {r_fold, 1'b0};

    assign env_i  = yq_reg[15:12];
    assign env_fr = yq_reg[11:0];
    assign tab_lo = mcg_pkg::pow2_neg({1'b0, env_i});
    assign tab_hi = mcg_pkg::pow2_neg(5'({1'b0, env_i} + 5'd1));
    assign env_e  = tab_lo - prod_reg[27:12];

    assign bpb_eff = (bpb_reg == 5'd0) ? 5'd1 : bpb_reg;
    assign cw      = pos_reg[31:16];
    assign clk_len = accent_reg ? mcg_pkg::ACCENT_LEN : mcg_pkg::NORMAL_LEN;
    assign vol_eff = (volume_reg > mcg_pkg::VOL_MAX) ? mcg_pkg::VOL_MAX : volume_reg;
    assign mag     = prod_reg[61:37];

    always_comb
    begin
        mod_t = {mod_rem_reg, whole_reg[15]};
        if (mod_t >= {1'b0, bpb_eff})
        begin
            mod_t = mod_t - {1'b0, bpb_eff};
        end
    end

    always_comb
    begin
        yr_sum = {1'b0, yr_reg} + {1'b0, (accent_reg ? mcg_pkg::ACCENT_R : mcg_pkg::NORMAL_R)};
        y_carry = (yr_sum >= {1'b0, clk_len});
    end

    assign left_sum  = 27'(left_reg) + 27'(click_reg);
    assign right_sum = 27'(right_reg) + 27'(click_reg);

    always_comb
    begin
        state_next     = state_reg;
        enable_next    = enable_reg;
        accent_en_next = accent_en_reg;
        volume_next    = volume_reg;
        bpb_next       = bpb_reg;
        lpv_next       = lpv_reg;
        lwb_next       = lwb_reg;
        crem_next      = crem_reg;
        accent_next    = accent_reg;
        phase_next     = phase_reg;
        yq_next        = yq_reg;
        yr_next        = yr_reg;
        playing_next   = playing_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mod_rem_next   = mod_rem_reg;
        mod_cnt_next   = mod_cnt_reg;
        whole_next     = whole_reg;
        prod_next      = prod_reg;
        z2_next        = z2_reg;
        sabs_next      = sabs_reg;
        env_next       = env_reg;
        gv_next        = gv_reg;
        click_next     = click_reg;
        out_valid_next = out_valid_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    playing_next = playing;
                    pos_next     = beat_position;
                    left_next    = left_in;
                    right_next   = right_in;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                click_next = '0;
                if (!enable_reg || !playing_reg)
                begin
                    lpv_next   = 1'b0;
                    crem_next  = '0;
                    state_next = S_OUT;
                end
                else if (!pos_reg[31])
                begin
                    lpv_next   = 1'b1;
                    lwb_next   = cw;
                    state_next = S_CLICK;
                    if (!lpv_reg || cw > lwb_reg)
                    begin
                        mod_rem_next = '0;
                        mod_cnt_next = '0;
                        whole_next   = cw;
                        state_next   = S_MOD;
                    end
                end
                else
                begin
                    lpv_next   = 1'b0;
                    lwb_next   = '0;
                    state_next = S_CLICK;
                end
            end
            S_MOD:
            begin
                // restoring remainder, one beat bit per cycle
                mod_rem_next = mod_t[4:0];
                whole_next   = {whole_reg[14:0], 1'b0};
                mod_cnt_next = mod_cnt_reg + 4'd1;
                if (mod_cnt_reg == 4'd15)
                begin
                    accent_next = (mod_t[4:0] == 5'd0) && accent_en_reg;
                    crem_next   = ((mod_t[4:0] == 5'd0) && accent_en_reg) ?
                                  mcg_pkg::ACCENT_LEN : mcg_pkg::NORMAL_LEN;
                    phase_next  = '0;
                    yq_next     = '0;
                    yr_next     = '0;
                    state_next  = S_CLICK;
                end
            end
            S_CLICK:
            begin
                click_next = '0;
                state_next = (crem_reg == '0) ? S_OUT : S_ZZ;
            end
            S_ZZ:
            begin
                mul_a      = 32'(z);
                mul_b      = 32'(z);
                prod_next  = mul_p;
                state_next = S_P1;
            end
            S_P1:
            begin
                z2_next    = prod_reg[30:15];
                mul_a      = 32'(mcg_pkg::SIN_C);
                mul_b      = 32'(prod_reg[30:15]);
                prod_next  = mul_p;
                state_next = S_P2;
            end
            S_P2:
            begin
                mul_a      = 32'(mcg_pkg::SIN_B - prod_reg[30:15]);
                mul_b      = 32'(z2_reg);
                prod_next  = mul_p;
                state_next = S_P3;
            end
            S_P3:
            begin
                mul_a      = 32'(mcg_pkg::SIN_A - prod_reg[30:15]);
                mul_b      = 32'(z);
                prod_next  = mul_p;
                state_next = S_ENV;
            end
            S_ENV:
            begin
                sabs_next  = prod_reg[30:15];
                mul_a      = 32'(tab_lo - tab_hi);
                mul_b      = 32'(env_fr);
                prod_next  = mul_p;
                state_next = S_GV;
            end
            S_GV:
            begin
                env_next   = env_e >> yq_reg[mcg_pkg::Y_W-1:16];
                mul_a      = 32'(accent_reg ? mcg_pkg::ACCENT_GAIN : mcg_pkg::NORMAL_GAIN);
                mul_b      = 32'(vol_eff);
                prod_next  = mul_p;
                state_next = S_SE;
            end
            S_SE:
            begin
                gv_next    = prod_reg[30:0];
                mul_a      = 32'(sabs_reg);
                mul_b      = 32'(env_reg);
                prod_next  = mul_p;
                state_next = S_ABG;
            end
            S_ABG:
            begin
                mul_a      = prod_reg[31:0];
                mul_b      = 32'(gv_reg);
                prod_next  = mul_p;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                click_next = u[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                phase_next = phase_reg + (accent_reg ? mcg_pkg::ACCENT_STEP
                                                     : mcg_pkg::NORMAL_STEP);
                crem_next  = crem_reg - 1'b1;
                // step the decay exponent k*DECAY/len to the next sample
                yq_next = yq_reg + (accent_reg ? mcg_pkg::ACCENT_Q : mcg_pkg::NORMAL_Q)
                          + mcg_pkg::Y_W'(y_carry);
                yr_next = y_carry ? mcg_pkg::LEN_W'(yr_sum - {1'b0, clk_len})
                                  : yr_sum[mcg_pkg::LEN_W-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    left_out_next  = mcg_pkg::sat24(left_sum);
                    right_out_next = mcg_pkg::sat24(right_sum);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            case (cfg_index)
                mcg_pkg::REG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        lpv_next  = 1'b0;
                        crem_next = '0;
                    end
                end
                mcg_pkg::REG_ACCENT_ENABLE: accent_en_next = cfg_data[0];
                mcg_pkg::REG_VOLUME:        volume_next    = cfg_data;
                mcg_pkg::REG_BEATS_PER_BAR: bpb_next       = cfg_data[4:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            accent_en_reg <= 1'b1;
            volume_reg    <= 16'd32768;
            bpb_reg       <= 5'd4;
            lpv_reg       <= 1'b0;
            lwb_reg       <= '0;
            crem_reg      <= '0;
            accent_reg    <= 1'b0;
            phase_reg     <= '0;
            yq_reg        <= '0;
            yr_reg        <= '0;
            playing_reg   <= 1'b0;
            pos_reg       <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            mod_rem_reg   <= '0;
            mod_cnt_reg   <= '0;
            whole_reg     <= '0;
            prod_reg      <= '0;
            z2_reg        <= '0;
            sabs_reg      <= '0;
            env_reg       <= '0;
            gv_reg        <= '0;
            click_reg     <= '0;
            out_valid_reg <= 1'b0;
            left_out_reg  <= '0;
            right_out_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            accent_en_reg <= accent_en_next;
            volume_reg    <= volume_next;
            bpb_reg       <= bpb_next;
            lpv_reg       <= lpv_next;
            lwb_reg       <= lwb_next;
            crem_reg      <= crem_next;
            accent_reg    <= accent_next;
            phase_reg     <= phase_next;
            yq_reg        <= yq_next;
            yr_reg        <= yr_next;
            playing_reg   <= playing_next;
            pos_reg       <= pos_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            mod_rem_reg   <= mod_rem_next;
            mod_cnt_reg   <= mod_cnt_next;
            whole_reg     <= whole_next;
            prod_reg      <= prod_next;
            z2_reg        <= z2_next;
            sabs_reg      <= sabs_next;
            env_reg       <= env_next;
            gv_reg        <= gv_next;
            click_reg     <= click_next;
            out_valid_reg <= out_valid_next;
            left_out_reg  <= left_out_next;
            right_out_reg <= right_out_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule
